### rtl/core/cpwab_pkg.sv
`timescale 1ns / 1ps
package cpwab_pkg;

    // Default frame geometry
    localparam int FRAME_WIDTH_DEF  = 800;
    localparam int FRAME_HEIGHT_DEF = 480;

    // Action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_BLEND = 1'b1;

    // Input transaction
    typedef struct packed {
        logic               action;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [31:0]        pixel_color;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [31:0] stored_color;
        logic        clipped;
    } t_out_item;

    // Mix one channel: floor((a*src + (255-a)*dst) / 255)
    function automatic logic [7:0] mix_channel(
        input logic [7:0] a,
        input logic [7:0] src,
        input logic [7:0] dst
    );
        logic [15:0] sum;
        logic [16:0] tmp;
        begin
            sum = 16'(a * src) + 16'((8'hff - a) * dst);
            // Divide by 255: (x + (x >> 8) + 1) >> 8, exact below 65535
            tmp = 17'(sum) + 17'(sum >> 8) + 17'd1;
            mix_channel = tmp[15:8];
        end
    endfunction

endpackage

### rtl/core/clipped_pixel_write_alpha_blend.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// One transaction per cycle while the result side does not stall.
// Stage one clips and forms the address, stage two reads the frame store,
// stage three blends and writes back while loading the result register.
// A back-to-back blend to the same pixel takes the last written word forwarded.
// Reset clears only valid bits; frame store contents are undefined until written.
// A stall on the result side freezes all stages and the store read data.
module clipped_pixel_write_alpha_blend
    import cpwab_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic signed [13:0] HALF_W = 14'(FRAME_WIDTH / 2);
    localparam logic signed [13:0] HALF_H = 14'(FRAME_HEIGHT / 2);
    localparam logic signed [13:0] LIM_W  = 14'(FRAME_WIDTH);
    localparam logic signed [13:0] LIM_H  = 14'(FRAME_HEIGHT);

    typedef struct packed {
        logic              valid;
        logic              action;
        logic              clipped;
        logic [31:0]       color;
        logic [ADDR_W-1:0] addr;
    } t_stage;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } t_wb;

    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_rd_data;

    t_stage    r_s1, n_s1;
    t_stage    r_s2;
    t_wb       r_wb;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic               w_adv;
    logic               w_take;
    logic signed [13:0] w_col;
    logic signed [13:0] w_row;
    logic               w_clip;
    logic [31:0]        w_dst;
    logic [31:0]        w_word;
    logic               w_mem_we;

    // Advance every stage together when the result register can load
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_take     = i_in_valid && w_adv;

    // Clip against the frame and form the store address
    always_comb begin
        w_col  = 14'(i_in_data.pos_x) + HALF_W;
        w_row  = 14'(i_in_data.pos_y) + HALF_H;
        w_clip = (w_col < 14'sd0) || (w_col >= LIM_W) ||
                 (w_row < 14'sd0) || (w_row >= LIM_H);
        n_s1.valid   = w_take;
        n_s1.action  = i_in_data.action;
        n_s1.clipped = w_clip;
        n_s1.color   = i_in_data.pixel_color;
        if (w_clip) begin
            n_s1.addr = '0;
        end else begin
            n_s1.addr = ADDR_W'($unsigned(w_row)) * ADDR_W'(FRAME_WIDTH)
                      + ADDR_W'($unsigned(w_col));
        end
    end

    // Pick the freshest copy of the destination word
    assign w_dst = (r_wb.valid && (r_wb.addr == r_s2.addr)) ? r_wb.data : r_rd_data;

    // Blend or pass the color through
    always_comb begin
        case (r_s2.action)
            ACT_BLEND: begin
                w_word = {8'h00,
                          mix_channel(r_s2.color[31:24], r_s2.color[23:16], w_dst[23:16]),
                          mix_channel(r_s2.color[31:24], r_s2.color[15:8],  w_dst[15:8]),
                          mix_channel(r_s2.color[31:24], r_s2.color[7:0],   w_dst[7:0])};
            end
            default: begin
                w_word = r_s2.color;
            end
        endcase
    end

    assign w_mem_we = w_adv && r_s2.valid && !r_s2.clipped;

    // Frame store: write back at stage three, read for stage two
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_s2.addr] <= w_word;
        end
        if (w_adv) begin
            r_rd_data <= r_mem[r_s1.addr];
        end
    end

    // Advance the pipeline and hold the last write for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_wb.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1        <= n_s1;
                r_s2        <= r_s1;
                r_out_valid <= r_s2.valid;
            end
            if (w_mem_we) begin
                r_wb.valid <= 1'b1;
                r_wb.addr  <= r_s2.addr;
                r_wb.data  <= w_word;
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data.stored_color <= r_s2.clipped ? 32'h0 : w_word;
            r_out_data.clipped      <= r_s2.clipped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A clipped point never reports a stored word
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clipped |-> o_out_data.stored_color == 32'h0)
        else $error("clipped result carries a nonzero word");

    // A blend always stores a zero alpha byte
    a_blend_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we && (r_s2.action == ACT_BLEND) |-> w_word[31:24] == 8'h00)
        else $error("blend wrote a nonzero alpha byte");

    // A result-side stall freezes stage two and its read data
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_s2) && $stable(r_rd_data))
        else $error("pipeline moved during a stall");

    // Input is refused only while a result waits
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused without a pending result");

endmodule
